/* rtl/leaky_integrate_fire_neuron_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the leaky integrate-and-fire neuron
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LEAKY_INTEGRATE_FIRE_NEURON_MACROS_SVH
`define LEAKY_INTEGRATE_FIRE_NEURON_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define LIF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define LIF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/lif_pkg.sv */
// ----------------------------------------------------------------------------
// LIF neuron package
// Widths, decay table, register map and configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lif_pkg;

   localparam int unsigned VOLT_W            = 32;
   localparam int unsigned TIME_W            = 32;
   localparam int unsigned TAU_TICKS_DEFAULT = 10;
   localparam int unsigned DECAY_STEPS       = 23;
   localparam int unsigned STEP_W            = $clog2(DECAY_STEPS);
   localparam int unsigned CSR_DATA_W        = 32;
   localparam int unsigned CSR_ADDR_W        = 4;

   // exp(-k) in unsigned Q0.32; entry zero is unused (unit gain)
   localparam logic [31:0] DECAY_Q32 [DECAY_STEPS] = '{
      32'd0,
      32'd1580030169, 32'd581260615, 32'd213833830, 32'd78665070, 32'd28939262,
      32'd10646160,   32'd3916503,   32'd1440801,   32'd530041,   32'd194991,
      32'd71733,      32'd26389,     32'd9708,      32'd3571,     32'd1314,
      32'd483,        32'd178,       32'd65,        32'd24,       32'd9,
      32'd3,          32'd1
   };

   typedef enum logic [1:0] {
      REG_FIRE_THRESHOLD   = 2'd0,
      REG_REST_AFTER_SPIKE = 2'd1,
      REG_START_VOLTAGE    = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic signed [VOLT_W-1:0] fire_threshold;
      logic signed [VOLT_W-1:0] rest_after_spike;
      logic signed [VOLT_W-1:0] start_voltage;
      logic                     start_load;
   } csr_cfg_type;

endpackage

`default_nettype wire

/* rtl/lif_req_if.sv */
// ----------------------------------------------------------------------------
// LIF request channel
// Valid/ready channel carrying one synaptic event per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lif_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] weighted_input;
   logic        [31:0] event_time;

   modport source (output valid, output weighted_input, output event_time, input ready);
   modport sink   (input valid, input weighted_input, input event_time, output ready);
endinterface

`default_nettype wire

/* rtl/lif_rsp_if.sv */
// ----------------------------------------------------------------------------
// LIF response channel
// Valid/ready channel carrying one spike flag and membrane voltage per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lif_rsp_if;
   logic               valid;
   logic               ready;
   logic               spiked;
   logic signed [31:0] membrane_voltage;

   modport source (output valid, output spiked, output membrane_voltage, input ready);
   modport sink   (input valid, input spiked, input membrane_voltage, output ready);
endinterface

`default_nettype wire

/* rtl/lif_csr.sv */
// ----------------------------------------------------------------------------
// LIF configuration registers
// APB-style register file: threshold, post-spike voltage, start voltage.
// ----------------------------------------------------------------------------
`default_nettype none

module lif_csr import lif_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output csr_cfg_type                cfg
);

   logic signed [VOLT_W-1:0] threshold_ff;
   logic signed [VOLT_W-1:0] rest_ff;
   logic signed [VOLT_W-1:0] start_ff;
   logic                     write_en;
   reg_index_type            reg_index;

   assign pready    = 1'b1;
   assign write_en  = psel && penable && pwrite;
   assign reg_index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         rest_ff      <= '0;
         start_ff     <= '0;
      end else if (write_en) begin
         unique case (reg_index)
            REG_FIRE_THRESHOLD:   threshold_ff <= pwdata;
            REG_REST_AFTER_SPIKE: rest_ff      <= pwdata;
            REG_START_VOLTAGE:    start_ff     <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_FIRE_THRESHOLD:   prdata = threshold_ff;
         REG_REST_AFTER_SPIKE: prdata = rest_ff;
         REG_START_VOLTAGE:    prdata = start_ff;
         default:              prdata = '0;
      endcase
   end

   assign cfg.fire_threshold   = threshold_ff;
   assign cfg.rest_after_spike = rest_ff;
   assign cfg.start_voltage    = pwdata;
   assign cfg.start_load       = write_en && (reg_index == REG_START_VOLTAGE);

endmodule

`default_nettype wire

/* rtl/lif_decay.sv */
// ----------------------------------------------------------------------------
// LIF membrane decay
// Scales the membrane by exp(-floor(elapsed / TAU_TICKS)), truncating to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lif_decay import lif_pkg::*; #(
   parameter int unsigned TAU_TICKS = TAU_TICKS_DEFAULT
) (
   input  wire logic signed [VOLT_W-1:0] membrane,
   input  wire logic        [TIME_W-1:0] elapsed,
   output logic signed      [VOLT_W-1:0] decayed
);

   logic [STEP_W-1:0]   step;
   logic                expired;
   logic [VOLT_W-1:0]   magnitude;
   logic [2*VOLT_W-1:0] product;
   logic [VOLT_W-1:0]   scaled;

   always_comb begin
      step = '0;
      for (int j = 1; j < DECAY_STEPS; j++) begin
         if (elapsed >= TIME_W'(j * TAU_TICKS)) begin
            step = STEP_W'(j);
         end
      end
   end

   assign expired   = elapsed >= TIME_W'(DECAY_STEPS * TAU_TICKS);
   assign magnitude = membrane[VOLT_W-1] ? VOLT_W'(-membrane) : VOLT_W'(membrane);
   assign product   = (2*VOLT_W)'(magnitude) * (2*VOLT_W)'(DECAY_Q32[step]);
   assign scaled    = product[2*VOLT_W-1:VOLT_W];

   always_comb begin
      if (expired) begin
         decayed = '0;
      end else if (step == '0) begin
         decayed = membrane;
      end else if (membrane[VOLT_W-1]) begin
         decayed = -$signed(scaled);
      end else begin
         decayed = $signed(scaled);
      end
   end

endmodule

`default_nettype wire

/* rtl/leaky_integrate_fire_neuron.sv */
// ----------------------------------------------------------------------------
// Leaky integrate-and-fire neuron
// Decays, integrates and thresholds one synaptic event per beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries an event (weighted_input, event_time); rsp_chan returns
//   one beat per event with spiked and the new membrane_voltage.
//   csr_* is an APB-style port: fire_threshold at 0x0, rest_after_spike at
//   0x4, start_voltage at 0x8. Writing start_voltage also loads the membrane.
//   Write registers only while no event is in flight.
//   An event accepted on req_chan is held in the input register, then moves
//   into the result register that drives rsp_chan.
//   Throughput: one event per cycle while rsp_chan does not stall; decay
//   multiply, saturating add and threshold compare sit in the single step
//   from input to result register, which also updates the membrane.
//   Reset clears the valid flags of both channel registers, sets the membrane
//   and configuration registers to zero and the last event time to zero.
//   When rsp_chan stalls, the result holds, one more event waits in the
//   input register, and req_chan.ready drops once both are full.
// ----------------------------------------------------------------------------
`default_nettype none
`include "leaky_integrate_fire_neuron_macros.svh"

module leaky_integrate_fire_neuron import lif_pkg::*; #(
   parameter int unsigned TAU_TICKS = TAU_TICKS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   lif_req_if.sink                    req_chan,
   lif_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   csr_cfg_type cfg;

   logic                     in_valid_ff;
   logic signed [VOLT_W-1:0] in_weight_ff;
   logic        [TIME_W-1:0] in_time_ff;
   logic signed [VOLT_W-1:0] membrane_ff;
   logic signed [VOLT_W-1:0] membrane_in;
   logic        [TIME_W-1:0] last_time_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_spiked_ff;
   logic signed [VOLT_W-1:0] rsp_voltage_ff;

   logic                     out_free;
   logic                     advance;
   logic        [TIME_W-1:0] elapsed;
   logic signed [VOLT_W-1:0] decayed;
   logic signed [VOLT_W:0]   sum;
   logic signed [VOLT_W-1:0] saturated;
   logic                     fire;

   lif_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   lif_decay #(
      .TAU_TICKS (TAU_TICKS)
   ) u_decay (
      .membrane (membrane_ff),
      .elapsed  (elapsed),
      .decayed  (decayed)
   );

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   assign elapsed = (in_time_ff >= last_time_ff) ? (in_time_ff - last_time_ff) : '0;
   assign sum     = {decayed[VOLT_W-1], decayed} + {in_weight_ff[VOLT_W-1], in_weight_ff};

   always_comb begin
      if (sum[VOLT_W] != sum[VOLT_W-1]) begin
         saturated = sum[VOLT_W] ? {1'b1, {(VOLT_W-1){1'b0}}} : {1'b0, {(VOLT_W-1){1'b1}}};
      end else begin
         saturated = sum[VOLT_W-1:0];
      end
   end

   assign fire        = saturated >= cfg.fire_threshold;
   assign membrane_in = fire ? cfg.rest_after_spike : saturated;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         membrane_ff  <= '0;
         last_time_ff <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cfg.start_load) begin
            membrane_ff <= cfg.start_voltage;
         end else if (advance) begin
            membrane_ff <= membrane_in;
         end
         if (advance) begin
            last_time_ff <= in_time_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_weight_ff <= req_chan.weighted_input;
         in_time_ff   <= req_chan.event_time;
      end
      if (advance) begin
         rsp_spiked_ff  <= fire;
         rsp_voltage_ff <= membrane_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.spiked           = rsp_spiked_ff;
   assign rsp_chan.membrane_voltage = rsp_voltage_ff;

   `LIF_ASSERT_NEXT(a_advance_shows, clock, reset, advance, rsp_valid_ff, "beat lost on way out")
   `LIF_ASSERT_NEXT(a_state_tracks, clock, reset, advance && !cfg.start_load, membrane_ff == rsp_voltage_ff, "membrane differs from result")
   `LIF_ASSERT_NEXT(a_spike_rest, clock, reset, advance && fire, rsp_voltage_ff == $past(cfg.rest_after_spike), "spike did not load rest voltage")
   `LIF_ASSERT_SAME(a_no_decay, clock, reset, advance && (elapsed < TIME_W'(TAU_TICKS)), decayed == membrane_ff, "decay applied within one tick period")

endmodule

`default_nettype wire

/* sim/leaky_integrate_fire_neuron_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Leaky integrate-and-fire neuron testbench
// Sends synaptic events through the request channel and checks each result
// beat against a predictor of the membrane. The predictor covers the stepped
// exponential leak, the saturating add and the threshold reset. Directed
// tests cover reset values, saturation, decay steps, timestamp ordering and
// register writes. A back-pressure test fills the block and stalls its input.
// Random phases then run under a range of register settings, with bursts of
// idling on both channels in all but the last phase.
// ----------------------------------------------------------------------------

module leaky_integrate_fire_neuron_tb import lif_pkg::*; ();

   localparam int unsigned TAU           = 10;
   localparam int unsigned LEAK_STEPS    = 23;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned RUN_LIMIT_NS  = 5_000_000;
   localparam int unsigned UNMAPPED_REG  = 3;
   localparam int unsigned REPORT_LINES  = 40;

   localparam logic signed [31:0] VOLT_TOP    = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VOLT_BOTTOM = 32'sh8000_0000;

   // exp(-k) in unsigned Q0.32, rounded to nearest; step zero is unit gain
   localparam logic [31:0] LEAK_Q32 [LEAK_STEPS] = '{
      32'd0,
      32'd1580030169, 32'd581260615, 32'd213833830, 32'd78665070, 32'd28939262,
      32'd10646160,   32'd3916503,   32'd1440801,   32'd530041,   32'd194991,
      32'd71733,      32'd26389,     32'd9708,      32'd3571,     32'd1314,
      32'd483,        32'd178,       32'd65,        32'd24,       32'd9,
      32'd3,          32'd1
   };

   typedef struct packed {
      logic               spiked;
      logic signed [31:0] voltage;
   } neuron_update_type;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   lif_req_if req_bus ();
   lif_rsp_if rsp_bus ();

   leaky_integrate_fire_neuron #(
      .TAU_TICKS (TAU)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   logic signed [31:0] shadow_membrane;
   logic        [31:0] shadow_last_time;
   logic signed [31:0] shadow_threshold;
   logic signed [31:0] shadow_rest;

   neuron_update_type due_updates [$];
   neuron_update_type oldest_update;

   logic [31:0] now_ticks;
   bit          bursts_on;
   int unsigned rsp_hold_cycles;

   int unsigned mismatches;
   int unsigned events_sent;
   int unsigned results_seen;
   int unsigned spikes_seen;
   int unsigned csr_writes;
   int unsigned full_leaks;
   int unsigned clipped_sums;
   int unsigned phases_run;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LINES)
         $display("%0t ns mismatch: %s", $time, what);
   endtask

   function automatic logic signed [31:0] leak(input logic signed [31:0] v,
                                               input logic [31:0] elapsed);
      logic [31:0]        k;
      longint unsigned    mag;
      logic signed [31:0] r;
      k = elapsed / TAU;
      if (k == 0)
         return v;
      if (k >= LEAK_STEPS) begin
         full_leaks++;
         return '0;
      end
      mag = (v < 0) ? longint'(-longint'(v)) : longint'(v);
      mag = (mag * LEAK_Q32[k]) >> 32;
      r = mag[31:0];
      return (v < 0) ? -r : r;
   endfunction

   function automatic neuron_update_type integrate_event(input logic signed [31:0] w,
                                                         input logic [31:0] now);
      logic [31:0]       elapsed;
      longint            sum;
      neuron_update_type u;
      elapsed = (now >= shadow_last_time) ? now - shadow_last_time : '0;
      sum = longint'(leak(shadow_membrane, elapsed)) + longint'(w);
      shadow_last_time = now;
      if (sum > longint'(VOLT_TOP)) begin
         sum = longint'(VOLT_TOP);
         clipped_sums++;
      end
      if (sum < longint'(VOLT_BOTTOM)) begin
         sum = longint'(VOLT_BOTTOM);
         clipped_sums++;
      end
      u.spiked = (sum >= longint'(shadow_threshold));
      u.voltage = u.spiked ? shadow_rest : sum[31:0];
      shadow_membrane = u.voltage;
      return u;
   endfunction

   task automatic send_event(input logic signed [31:0] w, input logic [31:0] now);
      if (bursts_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.weighted_input <= w;
      req_bus.event_time     <= now;
      do @(posedge clock); while (!req_bus.ready);
      due_updates.push_back(integrate_event(w, now));
      events_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (due_updates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input int unsigned index, input logic [31:0] value);
      bit mapped;
      mapped = 1'b1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(index * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_writes++;
      case (index)
         REG_FIRE_THRESHOLD:   shadow_threshold = value;
         REG_REST_AFTER_SPIKE: shadow_rest = value;
         REG_START_VOLTAGE:    shadow_membrane = value;
         default:              mapped = 1'b0;
      endcase
      @(posedge clock);
      if (mapped) begin
         csr_psel    <= 1'b1;
         csr_paddr   <= CSR_ADDR_W'(index * 4);
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         if (csr_prdata !== value)
            flag_mismatch($sformatf("register %0d reads %h, written %h",
                                    index, csr_prdata, value));
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] pick_weight(input int unsigned scale);
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: case ($urandom_range(0, 3))
               0:       return VOLT_TOP;
               1:       return VOLT_BOTTOM;
               2:       return -32'sd1;
               default: return 32'sd0;
            endcase
         default: return $signed($urandom_range(0, 2 * scale)) - $signed(scale);
      endcase
   endfunction

   task automatic advance_now();
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5:             now_ticks += $urandom_range(0, 9);
         6, 7, 8, 9, 10, 11, 12, 13:   now_ticks += $urandom_range(10, 229);
         14, 15:                       now_ticks += $urandom_range(230, 200000);
         16:                           now_ticks -= $urandom_range(1, 40);
         17:                           now_ticks = $urandom();
         default:                      now_ticks += $urandom_range(0, 30);
      endcase
   endtask

   task automatic load_registers(input logic signed [31:0] threshold,
                                 input logic signed [31:0] rest,
                                 input logic signed [31:0] start);
      wait_drained();
      csr_write(REG_FIRE_THRESHOLD, threshold);
      csr_write(REG_REST_AFTER_SPIKE, rest);
      csr_write(REG_START_VOLTAGE, start);
   endtask

   task automatic run_traffic_phase(input logic signed [31:0] threshold,
                                    input logic signed [31:0] rest,
                                    input logic signed [31:0] start,
                                    input int unsigned scale,
                                    input int unsigned count);
      load_registers(threshold, rest, start);
      repeat (count) begin
         advance_now();
         send_event(pick_weight(scale), now_ticks);
      end
      phases_run++;
   endtask

   task automatic test_reset_state();
      send_event(-32'sd100, 32'd0);
      send_event(32'sd100, 32'd3);
      send_event(32'sd0, 32'd9);
   endtask

   task automatic test_saturation();
      load_registers(VOLT_TOP, VOLT_BOTTOM, VOLT_TOP - 32'sd5);
      send_event(VOLT_TOP, 32'd9);
      send_event(VOLT_BOTTOM, 32'd9);
      send_event(-32'sd1, 32'd9);
      wait_drained();
      csr_write(REG_FIRE_THRESHOLD, VOLT_BOTTOM);
      send_event(32'sd0, 32'd9);
   endtask

   task automatic test_decay_steps();
      load_registers(VOLT_TOP, 32'sd0, VOLT_TOP);
      send_event(32'sd0, 32'd19);
      send_event(32'sd0, 32'd28);
      wait_drained();
      csr_write(REG_START_VOLTAGE, VOLT_BOTTOM);
      send_event(32'sd0, 32'd248);
      wait_drained();
      csr_write(REG_START_VOLTAGE, -32'sd1000001);
      send_event(32'sd0, 32'd263);
      send_event(32'sd0, 32'd493);
   endtask

   task automatic test_timestamps();
      wait_drained();
      csr_write(REG_START_VOLTAGE, 32'sd50000);
      send_event(32'sd3, 32'd100);
      send_event(32'sd0, 32'd0);
      wait_drained();
      csr_write(REG_START_VOLTAGE, -32'sd777777);
      send_event(32'sd5, 32'hFFFF_FFFF);
      send_event(-32'sd9, 32'hFFFF_FFFF);
   endtask

   task automatic test_register_writes();
      wait_drained();
      csr_write(UNMAPPED_REG, 32'hDEAD_BEEF);
      csr_write(REG_FIRE_THRESHOLD, -32'sd1);
      csr_write(REG_REST_AFTER_SPIKE, 32'sd123);
      send_event(32'sd3, 32'hFFFF_FFFF);
      send_event(-32'sd200, 32'hFFFF_FFFF);
   endtask

   task automatic test_backpressure();
      load_registers(32'sd4000, -32'sd1500, 32'sd0);
      bursts_on = 1'b0;
      rsp_hold_cycles = 64;
      repeat (12) begin
         advance_now();
         send_event(pick_weight(2000), now_ticks);
      end
      wait_drained();
   endtask

   task automatic test_random_traffic();
      bursts_on = 1'b1;
      run_traffic_phase(32'sd5000, -32'sd2000, 32'sd0, 1000, 120);
      run_traffic_phase(VOLT_BOTTOM, VOLT_TOP, 32'sd77, 1 << 20, 120);
      run_traffic_phase(VOLT_TOP, 32'sd0, VOLT_BOTTOM, 1 << 28, 120);
      run_traffic_phase(-32'sd3000, -32'sd50000, -32'sd1, 2000, 120);
      run_traffic_phase($urandom(), $urandom(), $urandom(), 1 << 28, 120);
      run_traffic_phase(32'sd1 << 24, -(32'sd1 << 23), 32'sd0, 1 << 22, 120);
      bursts_on = 1'b0;
      run_traffic_phase(32'sd100000, 32'sd0, 32'sd0, 30000, 120);
   endtask

   // hold off the result channel in bursts, or for a long stretch on request
   always begin : rsp_side
      @(posedge clock);
      if (rsp_hold_cycles != 0) begin
         rsp_bus.ready <= 1'b0;
         repeat (rsp_hold_cycles) @(posedge clock);
         rsp_hold_cycles = 0;
         rsp_bus.ready <= 1'b1;
      end else if (bursts_on && $urandom_range(0, 9) == 0) begin
         rsp_bus.ready <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (due_updates.size() == 0) begin
            flag_mismatch($sformatf("result beat %0d with nothing outstanding",
                                    results_seen));
         end else begin
            oldest_update = due_updates.pop_front();
            if (rsp_bus.spiked)
               spikes_seen++;
            if (rsp_bus.spiked !== oldest_update.spiked)
               flag_mismatch($sformatf("beat %0d spiked %b, expected %b", results_seen,
                                       rsp_bus.spiked, oldest_update.spiked));
            if (rsp_bus.membrane_voltage !== oldest_update.voltage)
               flag_mismatch($sformatf("beat %0d membrane_voltage %0d, expected %0d",
                                       results_seen, rsp_bus.membrane_voltage,
                                       oldest_update.voltage));
         end
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("timed out with %0d results outstanding", due_updates.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.weighted_input = '0;
      req_bus.event_time     = '0;
      rsp_bus.ready          = 1'b0;
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;
      shadow_membrane        = '0;
      shadow_last_time       = '0;
      shadow_threshold       = '0;
      shadow_rest            = '0;
      now_ticks              = '0;
      bursts_on              = 1'b1;
      rsp_hold_cycles        = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_saturation();
      test_decay_steps();
      test_timestamps();
      test_register_writes();
      test_backpressure();
      test_random_traffic();
      wait_drained();

      $display("Ran %0d events in %0d traffic phases: %0d spikes, %0d register writes.",
               events_sent, phases_run, spikes_seen, csr_writes);
      $display("Leak reached zero %0d times, sums clipped to the int32 range %0d times.",
               full_leaks, clipped_sums);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/lif_pkg.sv
rtl/lif_req_if.sv
rtl/lif_rsp_if.sv
rtl/lif_csr.sv
rtl/lif_decay.sv
rtl/leaky_integrate_fire_neuron.sv
sim/leaky_integrate_fire_neuron_tb.sv
